/* rtl/core/assert_macros.svh */
// Assertion macros used by the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, sampled on the rising clock edge and off during reset.
`define DFSCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define DFSCD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* rtl/core/dfscd_pkg.sv */
package dfscd_pkg;

  // Sizes of the graph store.
  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 256;
  localparam int VTX_W        = $clog2(MAX_VERTICES);
  localparam int EDGE_W       = $clog2(MAX_EDGES);
  localparam int LINK_W       = EDGE_W + 1;
  localparam int DEPTH_W      = VTX_W + 1;
  localparam int VCNT_W       = 7;
  localparam int CNT_W        = 9;
  localparam int CMD_W        = 2;
  localparam int FIELD_W      = 6;

  localparam logic [LINK_W-1:0]  NULL_LINK = LINK_W'(MAX_EDGES);
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [VCNT_W-1:0]  VCNT_MAX  = VCNT_W'(MAX_VERTICES);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_VERTICES);

  // Request command codes.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Vertex colors.
  localparam logic [1:0] COLOR_WHITE = 2'd0;
  localparam logic [1:0] COLOR_GRAY  = 2'd1;
  localparam logic [1:0] COLOR_BLACK = 2'd2;

  // Register word index of the configuration port.
  localparam logic REG_VCOUNT = 1'b0;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [LINK_W-1:0] edge_idx;
  } frame_t;

  typedef struct packed {
    logic              cycle_found;
    logic [CNT_W-1:0]  edges_examined;
    logic              load_error;
  } result_t;

  typedef struct packed {
    logic              dest_we;
    logic [EDGE_W-1:0] dest_waddr;
    logic [VTX_W-1:0]  dest_wdata;
    logic              next_we;
    logic [EDGE_W-1:0] next_waddr;
    logic [LINK_W-1:0] next_wdata;
    logic [EDGE_W-1:0] edge_raddr;
    logic              first_we;
    logic              first_clr;
    logic [VTX_W-1:0]  first_waddr;
    logic [EDGE_W-1:0] first_wdata;
    logic [VTX_W-1:0]  first_raddr;
    logic              last_we;
    logic [VTX_W-1:0]  last_waddr;
    logic [EDGE_W-1:0] last_wdata;
  } graph_req_t;

  typedef struct packed {
    logic [VTX_W-1:0]  dest;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] first;
    logic [EDGE_W-1:0] last;
    logic              head_valid;
  } graph_rsp_t;

  typedef struct packed {
    logic             color_we;
    logic             color_clr;
    logic [VTX_W-1:0] color_waddr;
    logic [1:0]       color_wdata;
    logic [VTX_W-1:0] color_raddr;
    logic             stack_we;
    logic [VTX_W-1:0] stack_waddr;
    frame_t           stack_wdata;
    logic [VTX_W-1:0] stack_raddr;
  } visit_req_t;

  typedef struct packed {
    logic [1:0] color;
    frame_t     frame;
  } visit_rsp_t;

endpackage

/* rtl/core/dfscd_if.sv */
// Request channel.
interface dfscd_in_if;
  import dfscd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [FIELD_W-1:0]   edge_source;
  logic [FIELD_W-1:0]   edge_target;
  modport source (output valid, command, edge_source, edge_target, input ready);
  modport sink   (input valid, command, edge_source, edge_target, output ready);
endinterface

// Result channel.
interface dfscd_out_if;
  import dfscd_pkg::*;
  logic             valid;
  logic             ready;
  logic             cycle_found;
  logic [CNT_W-1:0] edges_examined;
  logic             load_error;
  modport source (output valid, cycle_found, edges_examined, load_error, input ready);
  modport sink   (input valid, cycle_found, edges_examined, load_error, output ready);
endinterface

/* rtl/core/dfscd_graph_mem.sv */
module dfscd_graph_mem
  import dfscd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  graph_req_t req,
  output graph_rsp_t rsp
);

  logic [VTX_W-1:0]        dest_mem  [MAX_EDGES];
  logic [LINK_W-1:0]       next_mem  [MAX_EDGES];
  logic [EDGE_W-1:0]       first_mem [MAX_VERTICES];
  logic [EDGE_W-1:0]       last_mem  [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] first_vld_r;

  logic [VTX_W-1:0]  dest_rd_r;
  logic [LINK_W-1:0] next_rd_r;
  logic [EDGE_W-1:0] first_rd_r;
  logic              first_hit_r;
  logic [EDGE_W-1:0] last_rd_r;

  // Edge target and link memories.
  always_ff @(posedge clk) begin
    if (req.dest_we) begin
      dest_mem[req.dest_waddr] <= req.dest_wdata;
    end
    if (req.next_we) begin
      next_mem[req.next_waddr] <= req.next_wdata;
    end
    dest_rd_r <= dest_mem[req.edge_raddr];
    next_rd_r <= next_mem[req.edge_raddr];
  end

  // List head and tail memories; both are read at the same vertex.
  always_ff @(posedge clk) begin
    if (req.first_we) begin
      first_mem[req.first_waddr] <= req.first_wdata;
    end
    if (req.last_we) begin
      last_mem[req.last_waddr] <= req.last_wdata;
    end
    first_rd_r  <= first_mem[req.first_raddr];
    first_hit_r <= first_vld_r[req.first_raddr];
    last_rd_r   <= last_mem[req.first_raddr];
  end

  // A head whose valid bit is clear reads as an empty list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_vld_r <= '0;
    end else if (req.first_clr) begin
      first_vld_r <= '0;
    end else if (req.first_we) begin
      first_vld_r[req.first_waddr] <= 1'b1;
    end
  end

  assign rsp.dest       = dest_rd_r;
  assign rsp.next       = next_rd_r;
  assign rsp.first      = first_hit_r ? {1'b0, first_rd_r} : NULL_LINK;
  assign rsp.last       = last_rd_r;
  assign rsp.head_valid = first_vld_r[req.first_raddr];

endmodule

/* rtl/core/dfscd_visit_mem.sv */
module dfscd_visit_mem
  import dfscd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  visit_req_t req,
  output visit_rsp_t rsp
);

  logic [1:0]              color_mem [MAX_VERTICES];
  frame_t                  stack_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] color_vld_r;
  logic [1:0]              color_rd_r;
  logic                    color_hit_r;
  frame_t                  stack_rd_r;

  // Color memory and search stack.
  always_ff @(posedge clk) begin
    if (req.color_we) begin
      color_mem[req.color_waddr] <= req.color_wdata;
    end
    if (req.stack_we) begin
      stack_mem[req.stack_waddr] <= req.stack_wdata;
    end
    color_rd_r  <= color_mem[req.color_raddr];
    color_hit_r <= color_vld_r[req.color_raddr];
    stack_rd_r  <= stack_mem[req.stack_raddr];
  end

  // Every vertex turns white at the start of a search.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_vld_r <= '0;
    end else if (req.color_clr) begin
      color_vld_r <= '0;
    end else if (req.color_we) begin
      color_vld_r[req.color_waddr] <= 1'b1;
    end
  end

  assign rsp.color = color_hit_r ? color_rd_r : COLOR_WHITE;
  assign rsp.frame = stack_rd_r;

endmodule

/* rtl/core/dfscd_ctrl.sv */
module dfscd_ctrl
  import dfscd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [FIELD_W-1:0] in_source,
  input  logic [FIELD_W-1:0] in_target,
  input  logic [VCNT_W-1:0]  vertex_count,
  input  logic               out_busy,
  output logic               res_load,
  output result_t            res,
  output graph_req_t         greq,
  input  graph_rsp_t         grsp,
  output visit_req_t         vreq,
  input  visit_rsp_t         vrsp
);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_ADD_LINK  = 9'b000000010,
    S_START_RD  = 9'b000000100,
    S_START_CHK = 9'b000001000,
    S_EDGE      = 9'b000010000,
    S_POP       = 9'b000100000,
    S_EDGE_RD   = 9'b001000000,
    S_TGT       = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [DEPTH_W-1:0] start_r, start_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [VTX_W-1:0]   top_v_r, top_v_nxt;
  logic [LINK_W-1:0]  top_e_r, top_e_nxt;
  logic [VTX_W-1:0]   tgt_r, tgt_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [LINK_W-1:0]  loaded_r, loaded_nxt;
  logic               dropped_r, dropped_nxt;
  logic [EDGE_W-1:0]  link_e_r, link_e_nxt;
  logic               found_r, found_nxt;

  logic [VCNT_W-1:0]  n_act;
  logic               accept;
  logic [DEPTH_W-1:0] depth_dec;
  logic [DEPTH_W-1:0] depth_dec2;

  assign n_act      = (vertex_count > VCNT_MAX) ? VCNT_MAX : vertex_count;
  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign depth_dec  = depth_r - DEPTH_W'(1);
  assign depth_dec2 = depth_r - DEPTH_W'(2);

  assign res.cycle_found    = found_r;
  assign res.edges_examined = cnt_r;
  assign res.load_error     = dropped_r;

  // Sequencer for edge loading and the depth-first search.
  always_comb begin
    state_nxt   = state_r;
    start_nxt   = start_r;
    depth_nxt   = depth_r;
    top_v_nxt   = top_v_r;
    top_e_nxt   = top_e_r;
    tgt_nxt     = tgt_r;
    cnt_nxt     = cnt_r;
    loaded_nxt  = loaded_r;
    dropped_nxt = dropped_r;
    link_e_nxt  = link_e_r;
    found_nxt   = found_r;
    res_load    = 1'b0;
    greq        = '0;
    vreq        = '0;
    greq.first_raddr = VTX_W'(in_source);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            CMD_ADD: begin
              if (loaded_r >= LINK_W'(MAX_EDGES) || VCNT_W'(in_source) >= n_act ||
                  VCNT_W'(in_target) >= n_act) begin
                dropped_nxt = 1'b1;
              end else begin
                greq.dest_we    = 1'b1;
                greq.dest_waddr = loaded_r[EDGE_W-1:0];
                greq.dest_wdata = VTX_W'(in_target);
                greq.next_we    = 1'b1;
                greq.next_waddr = loaded_r[EDGE_W-1:0];
                greq.next_wdata = NULL_LINK;
                greq.last_we    = 1'b1;
                greq.last_waddr = VTX_W'(in_source);
                greq.last_wdata = loaded_r[EDGE_W-1:0];
                loaded_nxt      = loaded_r + LINK_W'(1);
                if (grsp.head_valid) begin
                  // The old tail comes out of memory next cycle.
                  link_e_nxt = loaded_r[EDGE_W-1:0];
                  state_nxt  = S_ADD_LINK;
                end else begin
                  greq.first_we    = 1'b1;
                  greq.first_waddr = VTX_W'(in_source);
                  greq.first_wdata = loaded_r[EDGE_W-1:0];
                end
              end
            end
            CMD_RUN: begin
              vreq.color_clr = 1'b1;
              cnt_nxt        = '0;
              start_nxt      = '0;
              depth_nxt      = '0;
              state_nxt      = S_START_RD;
            end
            CMD_CLEAR: begin
              greq.first_clr = 1'b1;
              loaded_nxt     = '0;
              dropped_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_ADD_LINK: begin
        greq.next_we    = 1'b1;
        greq.next_waddr = grsp.last;
        greq.next_wdata = {1'b0, link_e_r};
        state_nxt       = S_IDLE;
      end
      S_START_RD: begin
        if (VCNT_W'(start_r) >= n_act) begin
          found_nxt = 1'b0;
          state_nxt = S_DONE;
        end else begin
          vreq.color_raddr = start_r[VTX_W-1:0];
          greq.first_raddr = start_r[VTX_W-1:0];
          state_nxt        = S_START_CHK;
        end
      end
      S_START_CHK: begin
        if (vrsp.color != COLOR_WHITE) begin
          start_nxt = start_r + DEPTH_W'(1);
          state_nxt = S_START_RD;
        end else begin
          vreq.color_we    = 1'b1;
          vreq.color_waddr = start_r[VTX_W-1:0];
          vreq.color_wdata = COLOR_GRAY;
          top_v_nxt        = start_r[VTX_W-1:0];
          top_e_nxt        = grsp.first;
          depth_nxt        = DEPTH_W'(1);
          state_nxt        = S_EDGE;
        end
      end
      S_EDGE: begin
        if (top_e_r >= loaded_r) begin
          // Out-edges exhausted: the vertex is finished.
          vreq.color_we    = 1'b1;
          vreq.color_waddr = top_v_r;
          vreq.color_wdata = COLOR_BLACK;
          depth_nxt        = depth_dec;
          if (depth_r == DEPTH_W'(1)) begin
            start_nxt = start_r + DEPTH_W'(1);
            state_nxt = S_START_RD;
          end else begin
            vreq.stack_raddr = depth_dec2[VTX_W-1:0];
            state_nxt        = S_POP;
          end
        end else begin
          greq.edge_raddr = top_e_r[EDGE_W-1:0];
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
          state_nxt = S_EDGE_RD;
        end
      end
      S_POP: begin
        top_v_nxt = vrsp.frame.vertex;
        top_e_nxt = vrsp.frame.edge_idx;
        state_nxt = S_EDGE;
      end
      S_EDGE_RD: begin
        top_e_nxt = grsp.next;
        tgt_nxt   = grsp.dest;
        if (VCNT_W'(grsp.dest) >= n_act) begin
          state_nxt = S_EDGE;
        end else begin
          vreq.color_raddr = grsp.dest;
          greq.first_raddr = grsp.dest;
          state_nxt        = S_TGT;
        end
      end
      S_TGT: begin
        state_nxt = S_EDGE;
        if (vrsp.color == COLOR_GRAY) begin
          // Back edge to a vertex on the current path.
          found_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (vrsp.color == COLOR_WHITE && depth_r < DEPTH_MAX) begin
          vreq.color_we             = 1'b1;
          vreq.color_waddr          = tgt_r;
          vreq.color_wdata          = COLOR_GRAY;
          vreq.stack_we             = 1'b1;
          vreq.stack_waddr          = depth_dec[VTX_W-1:0];
          vreq.stack_wdata.vertex   = top_v_r;
          vreq.stack_wdata.edge_idx = top_e_r;
          top_v_nxt                 = tgt_r;
          top_e_nxt                 = grsp.first;
          depth_nxt                 = depth_r + DEPTH_W'(1);
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      loaded_r  <= '0;
      dropped_r <= 1'b0;
      cnt_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      loaded_r  <= loaded_nxt;
      dropped_r <= dropped_nxt;
      cnt_r     <= cnt_nxt;
      found_r   <= found_nxt;
    end
  end

  // Search working registers.
  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    depth_r  <= depth_nxt;
    top_v_r  <= top_v_nxt;
    top_e_r  <= top_e_nxt;
    tgt_r    <= tgt_nxt;
    link_e_r <= link_e_nxt;
  end

endmodule

/* rtl/core/dfs_cycle_detector_core.sv */
// Directed-graph cycle detector.
// Requests arrive on in_req: command 0 adds the edge edge_source -> edge_target,
// command 1 runs a three-color depth-first search, command 2 clears the graph,
// command 3 is dropped. Only a run produces a result on out_res: cycle_found,
// edges_examined (saturating at 511) and load_error (an edge was dropped since
// the last clear). vertex_count is written over the cfg_ APB port at address 0.
// An add whose source vertex already has out-edges also passes through a link
// state, since the old list tail is fetched from memory before it is linked.
// A run walks the start-vertex check, edge, target and pop states in turn, with
// each memory access going through the registered reads of the graph and visit
// memories, and then waits in its done state to hand off the result.
// The result sits in an output register; adds and clears are taken while it
// waits, but a later run holds its result until the receiver takes the first.
// Reset empties the graph, zeroes vertex_count and load_error and needs no
// clearing pass.
module dfs_cycle_detector_core
  import dfscd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  dfscd_in_if.sink            in_req,
  dfscd_out_if.source         out_res,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  logic [VCNT_W-1:0] vcount_r;
  logic              out_valid_r;
  result_t           res_r;
  result_t           res;
  logic              res_load;
  logic              out_busy;
  graph_req_t        greq;
  graph_rsp_t        grsp;
  visit_req_t        vreq;
  visit_rsp_t        vrsp;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_VCOUNT) ? {25'd0, vcount_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == REG_VCOUNT) begin
      vcount_r <= cfg_pwdata[VCNT_W-1:0];
    end
  end

  dfscd_graph_mem u_graph (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (greq),
    .rsp   (grsp)
  );

  dfscd_visit_mem u_visit (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (vreq),
    .rsp   (vrsp)
  );

  dfscd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_ready     (in_req.ready),
    .in_command   (in_req.command),
    .in_source    (in_req.edge_source),
    .in_target    (in_req.edge_target),
    .vertex_count (vcount_r),
    .out_busy     (out_busy),
    .res_load     (res_load),
    .res          (res),
    .greq         (greq),
    .grsp         (grsp),
    .vreq         (vreq),
    .vrsp         (vrsp)
  );

  // Result output register.
  assign out_busy = out_valid_r && !out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.cycle_found    = res_r.cycle_found;
  assign out_res.edges_examined = res_r.edges_examined;
  assign out_res.load_error     = res_r.load_error;

`include "assert_macros.svh"

  `DFSCD_ASSERT(a_run_busy, in_req.valid && in_req.ready && in_req.command == CMD_RUN |=> !in_req.ready, "run request did not hold off the input")
  `DFSCD_NEVER(a_cycle_count, out_valid_r && res_r.cycle_found && res_r.edges_examined == '0, "cycle reported with no edge examined")
  `DFSCD_ASSERT(a_result_src, $rose(out_valid_r) |-> $past(!in_req.ready), "result appeared without a search in progress")

endmodule

/* tb/dfscd_checker.sv */
module dfscd_checker
  import dfscd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dfscd_in_if         req,
  dfscd_out_if        res,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          runs_checked,
  output int          cycles_reported
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the graph store and the vertex count register.
  logic [VCNT_W-1:0] vcount;
  logic [VTX_W-1:0]  dest_mem [MAX_EDGES];
  logic [LINK_W-1:0] next_mem [MAX_EDGES];
  logic [LINK_W-1:0] head_mem [MAX_VERTICES];
  logic [EDGE_W-1:0] tail_mem [MAX_VERTICES];
  int                loaded;
  logic              dropped;
  result_t           expected_results[$];

  assign pending = expected_results.size();

  function automatic int used_vertices();
    return (vcount < MAX_VERTICES) ? int'(vcount) : MAX_VERTICES;
  endfunction

  function automatic void empty_graph();
    for (int i = 0; i < MAX_VERTICES; i++) head_mem[i] = NULL_LINK;
    loaded  = 0;
    dropped = 1'b0;
  endfunction

  function automatic void insert_edge(int src, int dst);
    int n;
    n = used_vertices();
    if (loaded >= MAX_EDGES || src >= n || dst >= n) begin
      dropped = 1'b1;
      return;
    end
    dest_mem[loaded] = VTX_W'(dst);
    next_mem[loaded] = NULL_LINK;
    if (head_mem[src] == NULL_LINK) begin
      head_mem[src] = LINK_W'(loaded);
    end else begin
      next_mem[tail_mem[src]] = LINK_W'(loaded);
    end
    tail_mem[src] = EDGE_W'(loaded);
    loaded++;
  endfunction

  // Three-color search with an explicit stack; stops at the first gray target.
  function automatic result_t search_graph();
    logic [1:0] color [MAX_VERTICES];
    int         stk_v [MAX_VERTICES];
    int         stk_e [MAX_VERTICES];
    int         n, depth, e, v, cnt;
    result_t    r;
    n   = used_vertices();
    cnt = 0;
    r   = '0;
    r.load_error = dropped;
    for (int i = 0; i < MAX_VERTICES; i++) color[i] = COLOR_WHITE;
    for (int s = 0; s < n; s++) begin
      if (color[s] != COLOR_WHITE) continue;
      color[s] = COLOR_GRAY;
      stk_v[0] = s;
      stk_e[0] = head_mem[s];
      depth = 1;
      while (depth > 0) begin
        e = stk_e[depth-1];
        if (e >= loaded || e >= MAX_EDGES) begin
          color[stk_v[depth-1]] = COLOR_BLACK;
          depth--;
          continue;
        end
        stk_e[depth-1] = next_mem[e];
        if (cnt < 511) cnt++;
        v = dest_mem[e];
        if (v >= n) continue;
        if (color[v] == COLOR_GRAY) begin
          r.cycle_found    = 1'b1;
          r.edges_examined = CNT_W'(cnt);
          return r;
        end
        if (color[v] == COLOR_WHITE && depth < MAX_VERTICES) begin
          color[v] = COLOR_GRAY;
          stk_v[depth] = v;
          stk_e[depth] = head_mem[v];
          depth++;
        end
      end
    end
    r.edges_examined = CNT_W'(cnt);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      vcount = '0;
      empty_graph();
      expected_results.delete();
      fail_count      = 0;
      runs_checked    = 0;
      cycles_reported = 0;
    end else begin
      // Register write over the configuration port.
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2:2] == 1'(REG_VCOUNT)) begin
        vcount = cfg_pwdata[VCNT_W-1:0];
      end
      // Accepted request updates the shadow graph or predicts a result.
      if (req.valid && req.ready) begin
        case (req.command)
          CMD_ADD: begin
            insert_edge(req.edge_source, req.edge_target);
          end
          CMD_CLEAR: begin
            empty_graph();
          end
          CMD_RUN: begin
            expected_results.push_back(search_graph());
          end
          default: ;
        endcase
      end
      // Accepted result is compared with the oldest prediction.
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no run pending");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          runs_checked++;
          if (res.cycle_found) cycles_reported++;
          if (res.cycle_found !== exp_r.cycle_found) begin
            $error("cycle_found expected %0d actual %0d", exp_r.cycle_found,
                   res.cycle_found);
            fail_count++;
          end
          if (res.edges_examined !== exp_r.edges_examined) begin
            $error("edges_examined expected %0d actual %0d", exp_r.edges_examined,
                   res.edges_examined);
            fail_count++;
          end
          if (res.load_error !== exp_r.load_error) begin
            $error("load_error expected %0d actual %0d", exp_r.load_error,
                   res.load_error);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dfscd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1350;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending, runs_checked, cycles_reported;
  int          cycle_count = 0;
  int          requests_sent = 0;
  bit          steady_input = 0;
  bit          steady_output = 0;

  dfscd_in_if  req_if ();
  dfscd_out_if res_if ();

  dfs_cycle_detector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (req_if),
    .out_res    (res_if),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  dfscd_checker chk (
    .clk(clk), .rst_n(rst_n), .req(req_if), .res(res_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .fail_count(fail_count), .pending(pending), .runs_checked(runs_checked),
    .cycles_reported(cycles_reported)
  );

  always #5 clk = ~clk;

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random stalls, plus one long hold-off while requests keep coming.
  initial begin
    int len;
    bit held;
    held = 0;
    res_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!held && cycle_count >= 1500) begin
        res_if.ready = 1'b0;
        held = 1;
        repeat (400) @(negedge clk);
      end else if (steady_output || $urandom_range(0, 99) < 65) begin
        res_if.ready = 1'b1;
      end else begin
        res_if.ready = 1'b0;
        len = pick_gap();
        repeat (len) @(negedge clk);
      end
    end
  end

  task automatic send_request(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] src,
                              logic [FIELD_W-1:0] dst);
    int gap;
    gap = steady_input ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.command     = cmd;
    req_if.edge_source = src;
    req_if.edge_target = dst;
    do @(posedge clk); while (!req_if.ready);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  // Drains all pending results, then lets an in-flight add or clear finish.
  task automatic wait_idle();
    @(negedge clk);
    req_if.valid = 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr  = 3'({REG_VCOUNT, 2'b00});
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  // One phase of random edges with runs, clears and unused commands sprinkled in; most edges in range.
  task automatic load_and_search(int n_vtx, int n_edges);
    int lim;
    logic [FIELD_W-1:0] s, t;
    lim = (n_vtx > MAX_VERTICES) ? MAX_VERTICES : n_vtx;
    for (int i = 0; i < n_edges; i++) begin
      if (lim > 0 && $urandom_range(0, 99) < 88) begin
        s = FIELD_W'($urandom_range(0, lim - 1));
        t = FIELD_W'($urandom_range(0, lim - 1));
      end else begin
        s = FIELD_W'($urandom);
        t = FIELD_W'($urandom);
      end
      send_request(CMD_ADD, s, t);
      if ($urandom_range(0, 7) == 0) begin
        send_request(CMD_RUN, FIELD_W'($urandom), FIELD_W'($urandom));
      end
      if ($urandom_range(0, 99) == 0) begin
        send_request(CMD_UNUSED, FIELD_W'($urandom), FIELD_W'($urandom));
      end
      if ($urandom_range(0, 149) == 0) begin
        send_request(CMD_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom));
      end
    end
    send_request(CMD_RUN, FIELD_W'($urandom), FIELD_W'($urandom));
  endtask

  initial begin
    int n_vtx, n_edges;
    req_if.valid       = 1'b0;
    req_if.command     = CMD_ADD;
    req_if.edge_source = '0;
    req_if.edge_target = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty graph, a simple chain, a back edge, dropped edges,
    // an ignored command, a self loop and a lowered vertex count.
    send_request(CMD_RUN, 6'd0, 6'd0);
    write_vertex_count(32'd4);
    send_request(CMD_ADD, 6'd0, 6'd1);
    send_request(CMD_ADD, 6'd1, 6'd2);
    send_request(CMD_ADD, 6'd2, 6'd3);
    send_request(CMD_RUN, 6'd63, 6'd63);
    send_request(CMD_ADD, 6'd3, 6'd1);
    send_request(CMD_RUN, 6'd0, 6'd0);
    send_request(CMD_ADD, 6'd3, 6'd63);
    send_request(CMD_ADD, 6'd63, 6'd0);
    send_request(CMD_UNUSED, 6'd1, 6'd2);
    send_request(CMD_RUN, 6'd0, 6'd0);
    send_request(CMD_CLEAR, 6'd63, 6'd63);
    send_request(CMD_ADD, 6'd2, 6'd2);
    send_request(CMD_RUN, 6'd0, 6'd0);
    send_request(CMD_CLEAR, 6'd0, 6'd0);
    send_request(CMD_ADD, 6'd0, 6'd3);
    send_request(CMD_ADD, 6'd0, 6'd1);
    send_request(CMD_RUN, 6'd0, 6'd0);
    write_vertex_count(32'd2);
    send_request(CMD_RUN, 6'd0, 6'd0);
    write_vertex_count(32'd1);
    send_request(CMD_RUN, 6'd0, 6'd0);

    // Fill the store past capacity with all 64 vertices in use.
    write_vertex_count(32'hFFFF_FF40);
    send_request(CMD_CLEAR, 6'd0, 6'd0);
    load_and_search(64, 270);

    // Random phases; some keep the old graph under a new vertex count.
    while (requests_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 9))
        0:       n_vtx = 127;
        1:       n_vtx = 64;
        2:       n_vtx = $urandom_range(0, 1);
        default: n_vtx = $urandom_range(2, 14);
      endcase
      steady_input  = ($urandom_range(0, 4) == 0);
      steady_output = ($urandom_range(0, 4) == 0);
      write_vertex_count({$urandom} & 32'hFFFF_FF80 | 32'(n_vtx));
      if ($urandom_range(0, 9) < 7) begin
        send_request(CMD_CLEAR, FIELD_W'($urandom), FIELD_W'($urandom));
      end
      n_edges = $urandom_range(0, 3 * ((n_vtx > 12) ? 12 : n_vtx) + 2);
      load_and_search(n_vtx, n_edges);
    end

    // Drain, then let the block settle.
    wait_idle();
    repeat (50) @(posedge clk);
    $display("Sent %0d requests; checked %0d search results, %0d of them with a cycle.",
             requests_sent, runs_checked, cycles_reported);
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
